/* rtl/core/lead_compensator_feedforward_steer_top_assert.svh */
// ---------------------------------------------------------------------------
// lead compensator steer assertion macros
// concurrent checks, compiled out when NO_ASSERTIONS is defined
// ---------------------------------------------------------------------------
`ifndef LEAD_COMPENSATOR_FEEDFORWARD_STEER_TOP_ASSERT_SVH
`define LEAD_COMPENSATOR_FEEDFORWARD_STEER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define LCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCFS_ASSERT(lbl, prop, msg)
`define LCFS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/lcfs_pkg.sv */
// ---------------------------------------------------------------------------
// lcfs_pkg
// widths, register codes and constants of the lead compensator steer block
// ---------------------------------------------------------------------------
`default_nettype none

package lcfs_pkg;

  localparam int GAIN_W    = 16;
  localparam int YAW_W     = 16;
  localparam int COORD_W   = 16;
  localparam int STEER_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // configuration register codes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN = 2'd2;

  localparam logic signed [GAIN_W-1:0] ZERO_GAIN_RST = 16'sd819;
  localparam logic signed [GAIN_W-1:0] POLE_GAIN_RST = 16'sd14746;
  localparam logic signed [GAIN_W-1:0] LOOP_GAIN_RST = 16'sd16384;

  localparam logic signed [STEER_W-1:0] STEER_MAX = 32'sh7fff_ffff;
  localparam logic signed [STEER_W-1:0] STEER_MIN = 32'sh8000_0000;

  // 2*y*1000 scaling of the feedforward divisor
  localparam logic signed [STEER_W-1:0] FF_DEN_SCALE = 32'sd2000;

  // quotient bits of the feedforward division
  localparam int DIV_STEPS = 48;

endpackage

`default_nettype wire

/* rtl/core/lcfs_channels.sv */
// ---------------------------------------------------------------------------
// lcfs channels
// valid/ready channel interfaces for input, result and configuration
// ---------------------------------------------------------------------------
`default_nettype none

interface lcfs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lcfs_pkg::YAW_W-1:0]    yaw_meas;
  logic signed [lcfs_pkg::COORD_W-1:0]  waypoint_x;
  logic signed [lcfs_pkg::COORD_W-1:0]  waypoint_y;
  modport source (output valid, yaw_meas, waypoint_x, waypoint_y, input ready);
  modport sink   (input valid, yaw_meas, waypoint_x, waypoint_y, output ready);
endinterface

interface lcfs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lcfs_pkg::STEER_W-1:0]  steer_cmd;
  logic                                 saturated;
  modport source (output valid, steer_cmd, saturated, input ready);
  modport sink   (input valid, steer_cmd, saturated, output ready);
endinterface

interface lcfs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lcfs_pkg::CFG_IDX_W-1:0]       index;
  logic [lcfs_pkg::CFG_DAT_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/lead_compensator_feedforward_steer_top.sv */
// ---------------------------------------------------------------------------
// lead_compensator_feedforward_steer_top
// lead compensator plus waypoint feedforward steer command, one shared
// multiplier and a radix-2 restoring divider under a small sequencer
// ---------------------------------------------------------------------------
//  channel  dir  payload                              transfer
//  in_ch    in   yaw_meas, waypoint_x, waypoint_y     valid & ready
//  out_ch   out  steer_cmd, saturated                 valid & ready
//  cfg_ch   in   index, data (gain registers)         valid & ready
//
//  an item passes through 8 multiply steps, 48 divider steps, round and
//  finish, then returns to idle where the next transfer is taken
//  the divider loop produces one quotient bit a cycle
//  synchronous active-low reset, no clearing pass; cfg_ch is always ready
//  a full output register stalls the finish step only; the next item waits
// ---------------------------------------------------------------------------
`default_nettype none

`include "lead_compensator_feedforward_steer_top_assert.svh"

module lead_compensator_feedforward_steer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  lcfs_in_if.sink   in_ch,
  lcfs_out_if.source out_ch,
  lcfs_cfg_if.sink  cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int CNT_W = $clog2(lcfs_pkg::DIV_STEPS);
  localparam int QUO_W = lcfs_pkg::DIV_STEPS;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic signed [lcfs_pkg::GAIN_W-1:0] zero_gain_r, pole_gain_r, loop_gain_r;
  logic signed [lcfs_pkg::STEER_W-1:0] last_cmd_r, last_cmd_nxt;
  logic signed [lcfs_pkg::YAW_W-1:0] last_yaw_r, last_yaw_nxt;

  logic signed [lcfs_pkg::YAW_W-1:0]   yaw_r, yaw_nxt;
  logic signed [lcfs_pkg::COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;

  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] prod_r, prod_nxt;

  logic signed [59:0] acc_r, acc_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [26:0] den_r, den_nxt;
  logic [26:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [27:0] rem_sh;
  logic [28:0] diff;
  logic signed [16:0] ay;

  logic signed [59:0] rnd;
  logic signed [35:0] lead_r, lead_nxt;
  logic signed [39:0] ff_mag;
  logic signed [39:0] ff_r, ff_nxt;
  logic signed [40:0] sum;

  logic out_valid_r, out_valid_nxt;
  logic signed [lcfs_pkg::STEER_W-1:0] steer_r, steer_nxt;
  logic sat_r, sat_nxt;
  logic out_free, in_xfer, out_load;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_load      = (state_r == S_FIN) && out_free;
  assign cfg_ch.ready  = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.steer_cmd = steer_r;
  assign out_ch.saturated = sat_r;

  assign ay = (y_r < 0) ? -17'(y_r) : 17'(y_r);

  // shared multiplier operand select, product registered in prod_r before use
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      3'd0: begin mul_a = 32'(loop_gain_r);  mul_b = 17'(yaw_r);       end
      3'd1: begin mul_a = 32'(loop_gain_r);  mul_b = 17'(zero_gain_r); end
      3'd2: begin mul_a = prod_r[31:0];      mul_b = 17'(last_yaw_r);  end
      3'd3: begin mul_a = last_cmd_r;        mul_b = 17'(pole_gain_r); end
      3'd4: begin mul_a = 32'(x_r);          mul_b = 17'(x_r);         end
      3'd5: begin mul_a = 32'(y_r);          mul_b = 17'(y_r);         end
      3'd6: begin mul_a = lcfs_pkg::FF_DEN_SCALE; mul_b = ay;          end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign rem_sh = {rem_r, quo_r[QUO_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  assign rnd    = acc_r + 60'sd8388608;
  assign ff_mag = {2'b00, quo_r[37:0]};
  assign sum    = 41'(lead_r) + 41'(ff_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    yaw_nxt       = yaw_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    lead_nxt      = lead_r;
    ff_nxt        = ff_r;
    last_cmd_nxt  = last_cmd_r;
    last_yaw_nxt  = last_yaw_r;
    steer_nxt     = steer_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          yaw_nxt   = in_ch.yaw_meas;
          x_nxt     = in_ch.waypoint_x;
          y_nxt     = in_ch.waypoint_y;
          step_nxt  = 3'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1: acc_nxt = 60'(prod_r) <<< 14;
          3'd3: acc_nxt = acc_r - 60'(prod_r);
          3'd4: acc_nxt = acc_r + (60'(prod_r) <<< 10);
          3'd5: sq_nxt  = prod_r[31:0];
          3'd6: sq_nxt  = sq_r + prod_r[31:0];
          3'd7: begin
            // dividend is the scaled square sum plus half the divisor
            den_nxt   = prod_r[26:0];
            quo_nxt   = {sq_r, 16'h0000} + QUO_W'(prod_r[26:1]);
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (!diff[28]) begin
          rem_nxt = diff[26:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[26:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(lcfs_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        lead_nxt  = 36'(rnd >>> 24);
        ff_nxt    = (y_r < 0) ? -ff_mag : ff_mag;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (y_r == 0) begin
            steer_nxt = lcfs_pkg::STEER_MAX;
            sat_nxt   = 1'b1;
          end else if (sum > 41'(lcfs_pkg::STEER_MAX)) begin
            steer_nxt = lcfs_pkg::STEER_MAX;
            sat_nxt   = 1'b1;
          end else if (sum < 41'(lcfs_pkg::STEER_MIN)) begin
            steer_nxt = lcfs_pkg::STEER_MIN;
            sat_nxt   = 1'b1;
          end else begin
            steer_nxt = sum[31:0];
            sat_nxt   = 1'b0;
          end
          last_cmd_nxt  = steer_nxt;
          last_yaw_nxt  = yaw_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      last_cmd_r  <= '0;
      last_yaw_r  <= '0;
      zero_gain_r <= lcfs_pkg::ZERO_GAIN_RST;
      pole_gain_r <= lcfs_pkg::POLE_GAIN_RST;
      loop_gain_r <= lcfs_pkg::LOOP_GAIN_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      last_cmd_r  <= last_cmd_nxt;
      last_yaw_r  <= last_yaw_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          lcfs_pkg::CFG_ZERO_GAIN: zero_gain_r <= cfg_ch.data;
          lcfs_pkg::CFG_POLE_GAIN: pole_gain_r <= cfg_ch.data;
          lcfs_pkg::CFG_LOOP_GAIN: loop_gain_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    yaw_r   <= yaw_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    sq_r    <= sq_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    lead_r  <= lead_nxt;
    ff_r    <= ff_nxt;
    steer_r <= steer_nxt;
    sat_r   <= sat_nxt;
  end

  `LCFS_ASSERT_NEXT(a_busy_after_in, in_ch.valid && in_ch.ready, state_r != S_IDLE, "input transfer did not start the sequencer")
  `LCFS_ASSERT(a_load_from_finish, $rose(out_valid_r) |-> $past(state_r == S_FIN), "result appeared outside the finish step")
  `LCFS_ASSERT(a_sat_at_rail, out_valid_r && sat_r |-> (steer_r == lcfs_pkg::STEER_MAX || steer_r == lcfs_pkg::STEER_MIN), "saturated flag without a full-scale command")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: lead compensator steer block testbench
// drives control steps and gain writes over valid/ready channels and checks
// every steer command against a cycle-free model held in the bench; random
// idling on both sides, one long output hold-off, gain sets incl. extremes
// ---------------------------------------------------------------------------
module tb_top;
  import lcfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 70;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } steer_step_t;

  typedef struct {
    logic signed [STEER_W-1:0] cmd;
    logic                      sat;
  } steer_cmd_t;

  logic clk;
  logic rst_n;

  lcfs_in_if  in_ch();
  lcfs_out_if out_ch();
  lcfs_cfg_if cfg_ch();

  lead_compensator_feedforward_steer_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // model copy of the gains and the loop memory
  logic signed [GAIN_W-1:0]  zero_g = ZERO_GAIN_RST;
  logic signed [GAIN_W-1:0]  pole_g = POLE_GAIN_RST;
  logic signed [GAIN_W-1:0]  loop_g = LOOP_GAIN_RST;
  logic signed [STEER_W-1:0] prev_cmd = '0;
  logic signed [YAW_W-1:0]   prior_yaw = '0;

  steer_step_t step_queue[$];
  steer_cmd_t  cmd_expq[$];

  int gap_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  int steps_taken = 0;
  int zero_y_steps = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int mismatches = 0;
  int gain_sets = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic steer_cmd_t steer_predict(steer_step_t s);
    longint acc, lead, ay, num, den, q, ff, sum;
    steer_cmd_t r;
    r.sat = 1'b0;
    if (s.y == 0) begin
      r.cmd = STEER_MAX;
      r.sat = 1'b1;
    end else begin
      // lead term with 40 fraction bits, rounded to 16
      acc = longint'(loop_g) * longint'(s.yaw) * 64'sd16384
          - longint'(loop_g) * longint'(zero_g) * longint'(prior_yaw)
          + longint'(pole_g) * longint'(prev_cmd) * 64'sd1024;
      lead = (acc + 64'sd8388608) >>> 24;
      ay = (s.y < 0) ? -longint'(s.y) : longint'(s.y);
      num = (longint'(s.x) * longint'(s.x) + longint'(s.y) * longint'(s.y)) * 64'sd65536;
      den = longint'(FF_DEN_SCALE) * ay;
      q = (num + den / 2) / den;
      ff = (s.y < 0) ? -q : q;
      sum = lead + ff;
      if (sum > longint'(STEER_MAX)) begin
        sum = longint'(STEER_MAX);
        r.sat = 1'b1;
      end else if (sum < longint'(STEER_MIN)) begin
        sum = longint'(STEER_MIN);
        r.sat = 1'b1;
      end
      r.cmd = sum[STEER_W-1:0];
    end
    prev_cmd = r.cmd;
    prior_yaw = s.yaw;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: pick_word = 16'sh7fff;
      1: pick_word = 16'sh8000;
      2, 3: pick_word = 16'($urandom_range(0, 80)) - 16'sd40;
      default: pick_word = 16'($urandom);
    endcase
  endfunction

  function automatic steer_step_t draw_step();
    steer_step_t s;
    s.yaw = pick_word();
    s.x = pick_word();
    s.y = ($urandom_range(0, 15) == 0) ? 16'sd0 : pick_word();
    return s;
  endfunction

  task automatic add_step(logic signed [15:0] yaw, logic signed [15:0] x,
                          logic signed [15:0] y);
    steer_step_t s;
    s.yaw = yaw;
    s.x = x;
    s.y = y;
    step_queue.push_back(s);
  endtask

  task automatic note_mismatch(string what, steer_cmd_t want, steer_cmd_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d (%s): expected cmd %0d sat %0b, got cmd %0d sat %0b",
               mismatches, what, want.cmd, want.sat, got.cmd, got.sat);
  endtask

  // wait until every step has been taken and answered, then let the block settle
  task automatic drain();
    do @(negedge clk); while (step_queue.size() != 0 || cmd_expq.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ZERO_GAIN: zero_g = val;
      CFG_POLE_GAIN: pole_g = val;
      CFG_LOOP_GAIN: loop_g = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic gain_phase(logic [15:0] a, logic [15:0] b, logic [15:0] k, int n, int pct);
    cfg_write(CFG_ZERO_GAIN, a);
    cfg_write(CFG_POLE_GAIN, b);
    cfg_write(CFG_LOOP_GAIN, k);
    gain_sets++;
    gap_pct = pct;
    repeat (n) step_queue.push_back(draw_step());
    drain();
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.yaw_meas   <= '0;
      in_ch.waypoint_x <= '0;
      in_ch.waypoint_y <= '0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (step_queue[0].y == 0) zero_y_steps++;
        cmd_expq.push_back(steer_predict(step_queue[0]));
        void'(step_queue.pop_front());
        steps_taken++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 17);
      end else if (!in_ch.valid && gap_left > 0) begin
        gap_left--;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left == 0 && step_queue.size() != 0) begin
          in_ch.valid      <= 1'b1;
          in_ch.yaw_meas   <= step_queue[0].yaw;
          in_ch.waypoint_x <= step_queue[0].x;
          in_ch.waypoint_y <= step_queue[0].y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        stall_left = $urandom_range(1, 17);
      out_ch.ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    steer_cmd_t got;
    steer_cmd_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cmd = out_ch.steer_cmd;
      got.sat = out_ch.saturated;
      results_seen++;
      if (got.sat === 1'b1) sat_seen++;
      if (cmd_expq.size() == 0) begin
        want.cmd = 'x;
        want.sat = 1'bx;
        note_mismatch("nothing expected", want, got);
      end else begin
        want = cmd_expq.pop_front();
        if (got.cmd !== want.cmd || got.sat !== want.sat) note_mismatch("steer", want, got);
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, cmd_expq.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed steps under the reset gains
    gap_pct = 25;
    add_step(16'sd0, 16'sd0, 16'sd1);
    add_step(16'sh7fff, 16'sd0, 16'sd1);
    add_step(16'sh8000, 16'sd0, -16'sd1);
    add_step(16'sd0, 16'sh7fff, 16'sd1);        // feedforward overflows high
    add_step(16'sd0, 16'sh7fff, -16'sd1);       // and low
    add_step(16'sd0, 16'sh8000, 16'sd0);        // zero y
    add_step(16'sh7fff, 16'sh7fff, 16'sd0);
    add_step(16'sd0, 16'sh8000, 16'sh8000);
    add_step(16'sd0, 16'sh7fff, 16'sh7fff);
    add_step(16'sh8000, 16'sh8000, 16'sh7fff);
    add_step(16'sd100, 16'sd1000, 16'sd2000);
    add_step(-16'sd100, -16'sd1000, -16'sd2000);
    add_step(16'sd0, 16'sd0, 16'sh8000);
    add_step(16'sh5555, 16'sh5555, 16'sh5555);
    add_step(16'shaaaa, 16'shaaaa, 16'shaaaa);
    add_step(16'sh7fff, 16'sh8000, -16'sd3);
    add_step(16'sh8000, 16'sh7fff, 16'sd3);
    add_step(16'sd4096, 16'sd50, 16'sd200);
    add_step(-16'sd4096, 16'sd50, -16'sd200);
    add_step(16'sd0, 16'sd1, 16'sd1);
    add_step(16'sd1, 16'sd0, -16'sd1);
    add_step(16'sd0, 16'sd0, 16'sd0);
    drain();

    // write to an unmapped index must leave the gains alone
    cfg_write(CFG_UNUSED, 16'h1234);
    repeat (10) step_queue.push_back(draw_step());
    drain();

    gain_phase(16'h8000, 16'h8000, 16'h8000, 60, 30);
    hold_req = 1'b1;
    gain_phase(16'h7fff, 16'h7fff, 16'h7fff, 60, 20);
    gain_phase(16'h0000, 16'h0000, 16'h0000, 40, 0);
    repeat (3) gain_phase(16'($urandom), 16'($urandom), 16'($urandom), 50, 35);
    // closing stretch without idling at the usual tuning
    gain_phase(ZERO_GAIN_RST, POLE_GAIN_RST, LOOP_GAIN_RST, 60, 0);

    $display("covered %0d control steps (%0d with zero y) across %0d gain settings",
             steps_taken, zero_y_steps, gain_sets);
    $display("checked %0d steer commands, %0d saturated, %0d mismatches",
             results_seen, sat_seen, mismatches);
    if (mismatches == 0 && cmd_expq.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lcfs_pkg.sv
rtl/core/lcfs_channels.sv
rtl/core/lead_compensator_feedforward_steer_top.sv
verif/tb_top.sv
